// ===== rtl/psw_pkg.sv =====
// Shared constants, types and command/status structs for the priority scheduler.
`default_nettype none
package psw_pkg;
  localparam int MAX_PROCESSES = 64;
  localparam int AW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int ID_W = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 22;
  localparam int TOT_W = 28;
  localparam int AVG_W = 30;
  localparam int FRAC_W = 8;
  localparam int DVD_W = TOT_W + FRAC_W;
  localparam int STEP_W = $clog2(DVD_W);
  localparam int IN_W = ID_W + BURST_W + PRIO_W;
  localparam int OUT_W = IN_W + 2 * TIME_W + 2 * AVG_W;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_ENTA,
    RK_SCAN,
    RK_SUM
  } rd_kind_t;

  typedef struct packed {
    logic load_en;
    logic pos_rd;
    logic scan_rd;
    logic swap1;
    logic swap2;
    logic sum_init;
    logic sum_rd;
    logic div_start;
    logic emit_ld;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic single;
    logic scan_last;
    logic pos_done;
    logic sum_last;
    logic div_busy;
    logic out_free;
    logic emit_last;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/psw_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating quotient.
`default_nettype none
module psw_div
  import psw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [CW-1:0]    divisor,
  output logic                  busy,
  output logic [AVG_W-1:0]      quotient
);
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    ge = trial >= {1'b0, divisor};
    diff = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    if (divisor == '0) quotient = '0;
    else if (quo_r[DVD_W-1:AVG_W] != '0) quotient = '1;
    else quotient = quo_r[AVG_W-1:0];
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

// ===== rtl/psw_dp.sv =====
// Datapath: batch store, selection scan, totals, dividers and output register.
`default_nettype none
module psw_dp
  import psw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tlast,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);
  entry_t mem [MAX_PROCESSES];
  entry_t q_r, ent_a_r, best_ent_r, wd;
  rd_kind_t kind_r, kind_nxt;
  logic [AW-1:0] q_addr_r, ra, wa, best_idx_r;
  logic we;
  logic [CW-1:0] cnt_r;
  logic drop_r;
  logic [AW-1:0] pos_r, scan_r, k_r;
  logic [TIME_W-1:0] rw_r, w_r;
  logic [TOT_W-1:0] wt_r, tt_r;
  logic [TIME_W:0] tat_s, emit_s;
  logic [TIME_W-1:0] tat_q, emit_tat;
  logic [TOT_W:0] wt_s, tt_s;
  logic in_fire, full;
  logic [CW-1:0] k_ext;
  logic busy_w, busy_t;
  logic [AVG_W-1:0] avg_w, avg_t;
  logic out_vld_r;
  logic [OUT_W-1:0] out_data_r;
  logic out_last_r, out_user_r;

  assign full = cnt_r == CW'(MAX_PROCESSES);
  assign in_tready = cmd.load_en;
  assign in_fire = in_tvalid && cmd.load_en;
  assign k_ext = {{(CW-AW){1'b0}}, k_r};

  always_comb begin
    ra = k_r;
    kind_nxt = RK_NONE;
    if (cmd.pos_rd) begin
      ra = pos_r;
      kind_nxt = RK_ENTA;
    end else if (cmd.scan_rd) begin
      ra = scan_r;
      kind_nxt = RK_SCAN;
    end else if (cmd.sum_rd) begin
      kind_nxt = RK_SUM;
    end
    we = 1'b0;
    wa = cnt_r[AW-1:0];
    wd = in_tdata;
    if (in_fire && !full) begin
      we = 1'b1;
    end else if (cmd.swap1) begin
      we = 1'b1;
      wa = pos_r;
      wd = best_ent_r;
    end else if (cmd.swap2) begin
      we = 1'b1;
      wa = best_idx_r;
      wd = ent_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    q_r <= mem[ra];
    q_addr_r <= ra;
  end

  always_comb begin
    tat_s = {1'b0, rw_r} + {{(TIME_W-BURST_W+1){1'b0}}, q_r.burst};
    tat_q = tat_s[TIME_W] ? '1 : tat_s[TIME_W-1:0];
    wt_s = {1'b0, wt_r} + {{(TOT_W-TIME_W+1){1'b0}}, rw_r};
    tt_s = {1'b0, tt_r} + {{(TOT_W-TIME_W+1){1'b0}}, tat_q};
    emit_s = {1'b0, w_r} + {{(TIME_W-BURST_W+1){1'b0}}, q_r.burst};
    emit_tat = emit_s[TIME_W] ? '1 : emit_s[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= RK_NONE;
      cnt_r <= '0;
      drop_r <= 1'b0;
      pos_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      if (in_fire) begin
        if (full) drop_r <= 1'b1;
        else cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.swap2) pos_r <= pos_r + 1'b1;
      if (cmd.emit_ld) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      if (cmd.emit_ld && sts.emit_last) begin
        cnt_r <= '0;
        drop_r <= 1'b0;
        pos_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_rd) scan_r <= pos_r + 1'b1;
    else if (cmd.scan_rd) scan_r <= scan_r + 1'b1;
    case (kind_r)
      RK_ENTA: begin
        ent_a_r <= q_r;
        best_ent_r <= q_r;
        best_idx_r <= q_addr_r;
      end
      RK_SCAN: begin
        if (q_r.prio < best_ent_r.prio) begin
          best_ent_r <= q_r;
          best_idx_r <= q_addr_r;
        end
      end
      RK_SUM: begin
        rw_r <= tat_q;
        wt_r <= wt_s[TOT_W] ? '1 : wt_s[TOT_W-1:0];
        tt_r <= tt_s[TOT_W] ? '1 : tt_s[TOT_W-1:0];
      end
      default: ;
    endcase
    if (cmd.sum_init) begin
      k_r <= '0;
      rw_r <= '0;
      wt_r <= '0;
      tt_r <= '0;
    end else if (cmd.sum_rd) begin
      k_r <= k_r + 1'b1;
    end else if (cmd.div_start) begin
      k_r <= '0;
      w_r <= '0;
    end else if (cmd.emit_ld) begin
      k_r <= k_r + 1'b1;
      w_r <= emit_tat;
      out_data_r <= {avg_t, avg_w, emit_tat, w_r, q_r.prio, q_r.burst, q_r.id};
      out_last_r <= sts.emit_last;
      out_user_r <= drop_r;
    end
  end

  psw_div u_div_wait (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend({wt_r, {FRAC_W{1'b0}}}), .divisor(cnt_r),
    .busy(busy_w), .quotient(avg_w)
  );

  psw_div u_div_tat (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend({tt_r, {FRAC_W{1'b0}}}), .divisor(cnt_r),
    .busy(busy_t), .quotient(avg_t)
  );

  always_comb begin
    sts.last_fire = in_fire && in_tlast;
    sts.single = cnt_r <= CW'(1);
    sts.scan_last = ({1'b0, scan_r} + 1'b1) == (AW+1)'(cnt_r);
    sts.pos_done = ({2'b0, pos_r} + 2'd2) >= (AW+2)'(cnt_r);
    sts.sum_last = (k_ext + 1'b1) == cnt_r;
    sts.div_busy = busy_w || busy_t;
    sts.out_free = !out_vld_r || out_tready;
    sts.emit_last = (k_ext + 1'b1) == cnt_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_user_r;
endmodule
`default_nettype wire

// ===== rtl/psw_ctrl.sv =====
// Controller: sequences load, selection sort, totals, averaging and emission.
`default_nettype none
module psw_ctrl
  import psw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_LOAD, S_START, S_POS, S_SCAN, S_SCAN_END, S_SWAP1, S_SWAP2,
    S_SUM_INIT, S_SUM, S_SUM_END, S_DIV_START, S_DIV_WAIT, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (sts.last_fire) state_nxt = S_START;
      end
      S_START: state_nxt = sts.single ? S_SUM_INIT : S_POS;
      S_POS: begin
        cmd.pos_rd = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_SWAP1;
      S_SWAP1: begin
        cmd.swap1 = 1'b1;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.swap2 = 1'b1;
        state_nxt = sts.pos_done ? S_SUM_INIT : S_POS;
      end
      S_SUM_INIT: begin
        cmd.sum_init = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_rd = 1'b1;
        if (sts.sum_last) state_nxt = S_SUM_END;
      end
      S_SUM_END: state_nxt = S_DIV_START;
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (!sts.div_busy) state_nxt = S_EMIT_RD;
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt = sts.emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/priority_schedule_wait_times.sv =====
// Top level of the non-preemptive priority scheduler.
// Input channel in_*: one process per item; in_tdata = {priority, burst, id}
// from the lowest bit up as id[15:0], burst[31:16], priority[39:32];
// in_tlast closes the batch. Up to MAX_PROCESSES items are stored, further
// items are dropped and flagged on every result of that batch (out_tuser).
// After the closing item the batch is sorted by selection sort in one store
// with one read and one write port, the scan making one compare per cycle.
// Totals follow, then the two averages in bit-serial dividers, then the
// results leave one at a time in sorted order through the output register.
// in_tready is high only while loading. Results sit in an output register;
// a stall on out_tready holds it and pauses emission without loss.
// Synchronous active-low reset empties the batch and the output register.
`default_nettype none
module priority_schedule_wait_times
  import psw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // process_id, burst_time, priority_req
  input  wire logic             in_tlast,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // process_id_res, burst_time_res, priority_res, wait_time, turnaround_time,
  // avg_wait_q8, avg_turnaround_q8
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser   // overflow
);
  cmd_t cmd;
  sts_t sts;

  psw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  psw_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the priority scheduler: batches in, schedule out.
`default_nettype none
module tb;
  import psw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [AVG_W-1:0]   avg_tat;
    logic [AVG_W-1:0]   avg_wait;
    logic [TIME_W-1:0]  tat;
    logic [TIME_W-1:0]  wait_t;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
    logic               ovf;
    logic               last;
  } sched_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_items = 0;
  int unsigned n_fail = 0;

  entry_t batch_q[$];
  logic   batch_dropped = 1'b0;
  sched_t sched_q[$];

  priority_schedule_wait_times i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned sat(longint unsigned v, longint unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // selection sort, then wait / turnaround sums and averages, then the expected results
  task automatic schedule_batch();
    entry_t e[$];
    entry_t t;
    int n, best;
    longint unsigned run, tat, wt, tt, aw, at;
    sched_t r;
    e = batch_q;
    n = e.size();
    for (int a = 0; a < n; a++) begin
      best = a;
      for (int b = a + 1; b < n; b++)
        if (e[b].prio < e[best].prio) best = b;
      t = e[a]; e[a] = e[best]; e[best] = t;
    end
    run = 0; wt = 0; tt = 0;
    for (int k = 0; k < n; k++) begin
      tat = sat(run + e[k].burst, 64'h3FFFFF);
      wt = sat(wt + run, 64'hFFFFFFF);
      tt = sat(tt + tat, 64'hFFFFFFF);
      run = tat;
    end
    aw = (n == 0) ? 0 : sat((wt << 8) / n, 64'h3FFFFFFF);
    at = (n == 0) ? 0 : sat((tt << 8) / n, 64'h3FFFFFFF);
    run = 0;
    for (int k = 0; k < n; k++) begin
      tat = sat(run + e[k].burst, 64'h3FFFFF);
      r.id = e[k].id; r.burst = e[k].burst; r.prio = e[k].prio;
      r.wait_t = TIME_W'(run); r.tat = TIME_W'(tat);
      r.avg_wait = AVG_W'(aw); r.avg_tat = AVG_W'(at);
      r.ovf = batch_dropped; r.last = (k == n - 1);
      sched_q.push_back(r);
      run = tat;
    end
    batch_q.delete();
    batch_dropped = 1'b0;
  endtask

  task automatic send_process(logic [15:0] id, logic [15:0] burst, logic [7:0] prio,
                              logic last);
    entry_t e;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    e.id = id; e.burst = burst; e.prio = prio;
    in_tvalid <= 1'b1;
    in_tdata <= e;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (batch_q.size() < MAX_PROCESSES) batch_q.push_back(e);
    else batch_dropped = 1'b1;
    if (last) schedule_batch();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_single_extremes();
    send_process(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_process(16'h0000, 16'h0000, 8'h00, 1'b1);
    send_process(16'hA5A5, 16'h5A5A, 8'hAA, 1'b0);
    send_process(16'h5A5A, 16'hA5A5, 8'h55, 1'b1);
  endtask

  task automatic test_ties_and_order();
    send_process(16'd1, 16'd10, 8'd3, 1'b0);
    send_process(16'd2, 16'd20, 8'd1, 1'b0);
    send_process(16'd3, 16'd30, 8'd3, 1'b0);
    send_process(16'd4, 16'd40, 8'd1, 1'b0);
    send_process(16'd5, 16'd50, 8'd0, 1'b0);
    send_process(16'd6, 16'd60, 8'd255, 1'b0);
    send_process(16'd7, 16'd70, 8'd3, 1'b1);
  endtask

  task automatic test_full_wide_bursts();
    for (int i = 0; i < MAX_PROCESSES; i++)
      send_process(i[15:0], 16'hFFFF, 8'(255 - i), i == MAX_PROCESSES - 1);
  endtask

  task automatic test_overflow_drop();
    for (int i = 0; i < MAX_PROCESSES + 2; i++)
      send_process(16'($urandom), 16'($urandom), 8'($urandom), i == MAX_PROCESSES + 1);
    drain();
    for (int i = 0; i < MAX_PROCESSES; i++)
      send_process(16'($urandom), 16'($urandom_range(3)), 8'($urandom_range(1)), 1'b0);
    send_process(16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
  endtask

  task automatic test_random_batches(int unsigned tx_pct, int unsigned rx_pct,
                                     int unsigned count);
    int unsigned stop, n;
    logic [15:0] burst;
    logic [7:0]  prio;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    stop = n_items + count;
    while (n_items < stop) begin
      case ($urandom_range(15))
        0:       n = MAX_PROCESSES;
        1:       n = MAX_PROCESSES + $urandom_range(1, 3);
        default: n = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < n; i++) begin
        burst = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 100));
        prio  = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(0, 3));
        send_process(16'($urandom), burst, prio, i == n - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    sched_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser, out_tlast};
      if (sched_q.size() == 0) begin
        $error("unexpected result item");
        n_fail++;
      end else begin
        exp_r = sched_q.pop_front();
        if (got.id != exp_r.id) begin
          $error("process_id_res exp %0d got %0d", exp_r.id, got.id); n_fail++;
        end
        if (got.burst != exp_r.burst) begin
          $error("burst_time_res exp %0d got %0d", exp_r.burst, got.burst); n_fail++;
        end
        if (got.prio != exp_r.prio) begin
          $error("priority_res exp %0d got %0d", exp_r.prio, got.prio); n_fail++;
        end
        if (got.wait_t != exp_r.wait_t) begin
          $error("wait_time exp %0d got %0d", exp_r.wait_t, got.wait_t); n_fail++;
        end
        if (got.tat != exp_r.tat) begin
          $error("turnaround_time exp %0d got %0d", exp_r.tat, got.tat); n_fail++;
        end
        if (got.avg_wait != exp_r.avg_wait) begin
          $error("avg_wait_q8 exp %0d got %0d", exp_r.avg_wait, got.avg_wait); n_fail++;
        end
        if (got.avg_tat != exp_r.avg_tat) begin
          $error("avg_turnaround_q8 exp %0d got %0d", exp_r.avg_tat, got.avg_tat);
          n_fail++;
        end
        if (got.ovf != exp_r.ovf) begin
          $error("overflow exp %0d got %0d", exp_r.ovf, got.ovf); n_fail++;
        end
        if (got.last != exp_r.last) begin
          $error("last_result exp %0d got %0d", exp_r.last, got.last); n_fail++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 24;
    rx_stall_pct = 79;
    test_single_extremes();
    test_ties_and_order();
    drain();
    test_full_wide_bursts();
    test_overflow_drop();
    test_random_batches(24, 79, 15);
    test_random_batches(79, 24, 15);
    test_random_batches(0, 0, 10);
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_fail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
